@@ design/scic_pkg.sv @@
// Shared constants for the segment and circle intersection pipeline.
`timescale 1ns / 1ps
`default_nettype none
package scic_pkg;

    // Default coordinate format, signed Q16.16
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Tolerance register
    localparam int             TOL_W     = 31;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

    // Width of one operand slice in the pipelined multipliers
    localparam int MUL_CHUNK = 34;

endpackage
`default_nettype wire

@@ design/segment_circle_intersection.sv @@
// Top level: segment and circle intersection pipeline with stream ports.
//
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+-------------------------------
//  s_axis    | in        | i_s_axis_tvalid/o_s_axis_tready | segment ends, center, radius
//  m_axis    | out       | o_m_axis_tvalid/i_m_axis_tready | count, two points; tuser=degen
//  cfg       | in        | i_cfg_we                        | tolerance (unsigned Q15.16)
//
// One item enters per cycle. The pipeline depth is set mostly by the 2*COORD_WIDTH
// stage square root and the COORD_WIDTH+2 stage dividers.
// All stages advance together; when a result sits unaccepted at the output, the
// whole pipeline holds and o_s_axis_tready drops, so nothing is lost or repeated.
// Reset clears the valid bits and loads the tolerance with its default.
`timescale 1ns / 1ps
`default_nettype none
module segment_circle_intersection
    import scic_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, center_x, center_y, radius
    input  wire logic [((7*COORD_WIDTH-1+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // point_count, first_x, first_y, second_x, second_y
    output logic [((2+4*COORD_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // degenerate
    output logic                        o_m_axis_tuser,
    input  wire logic                   i_cfg_we,
    input  wire logic [TOL_W-1:0]       i_cfg_wdata
);

    localparam int W      = COORD_WIDTH;
    localparam int DW     = W + 1;
    localparam int AW     = 2 * DW;
    localparam int BW     = AW + 1;
    localparam int PW     = 2 * AW;
    localparam int DDW    = PW + 1;
    localparam int SQW    = 2 * W;
    localparam int NSW    = BW + 1;
    localparam int TW     = 2 * TOL_W + 2 * FRAC_BITS;
    localparam int CW     = ((DDW + 2 > TW + 1) ? DDW + 2 : TW + 1) + 1;
    localparam int OUT_TDW = ((2 + 4 * W + 7) / 8) * 8;

    localparam int CH  = MUL_CHUNK;
    localparam int L1  = ((DW + CH - 1) / CH) * ((DW + CH - 1) / CH);
    localparam int L2  = ((AW + CH - 1) / CH) * ((AW + CH - 1) / CH);
    localparam int L3  = ((DW + CH - 1) / CH) * ((AW + CH - 1) / CH);
    localparam int LS  = SQW;
    localparam int LD  = DW + 1;

    localparam int S2  = 2;
    localparam int S3  = S2 + L1;
    localparam int S4  = S3 + 1;
    localparam int S5  = S4 + 1;
    localparam int S6  = S5 + L2;
    localparam int S7  = S6 + 1;
    localparam int S8  = S7 + LS;
    localparam int S9  = S8 + 1;
    localparam int S10 = S9 + 1;
    localparam int S11 = S10 + L3;
    localparam int S12 = S11 + LD;
    localparam int S13 = S12 + 1;

    localparam int KL = S12 - S2 + 1;
    localparam int ML = S11 - S4 + 1;
    localparam int FL = S8 - S7;
    localparam int TL = S12 - S10 + 1;

    typedef struct packed {
        logic [W-1:0]  sx;
        logic [W-1:0]  sy;
        logic [DW-1:0] mdx;
        logic [DW-1:0] mdy;
        logic          sdx;
        logic          sdy;
        logic          sex;
        logic          sey;
        logic          degen;
    } t_keep;

    typedef struct packed {
        logic [AW-1:0] a;
        logic [BW-1:0] b;
    } t_mid;

    typedef struct packed {
        logic neg;
        logic tang;
        logic dpos;
    } t_flag;

    typedef struct packed {
        logic ok0;
        logic ok1;
    } t_ok;

    logic ce;

    // tolerance and its square
    logic [TOL_W-1:0]   r_tol;
    logic [2*TOL_W-1:0] r_tol2;

    // valid bits and side lines
    logic  r_v    [1:S13];
    t_keep r_keep [KL];
    t_mid  r_mid  [ML];
    t_flag r_flag [FL];
    t_ok   r_tail [TL];

    // input fields
    logic [W-1:0]   w_sx, w_sy, w_ex, w_ey, w_cx, w_cy;
    logic [W-2:0]   w_rad;

    logic [DW-1:0]  r1_dx, r1_dy, r1_ex, r1_ey;
    logic [W-1:0]   r1_sx, r1_sy;
    logic [W-2:0]   r1_r;

    t_keep          n_keep;
    logic [DW-1:0]  r2_mex, r2_mey, r2_r;

    logic [AW-1:0]  w_pxx, w_pyy, w_pxe, w_pye, w_pxy, w_pyx, w_prr;
    t_keep          w_k3;
    t_mid           n_mid;
    logic [BW-1:0]  n_x;
    logic [BW-1:0]  r4_x;
    logic [AW-1:0]  r4_rr;

    logic [AW-1:0]  r5_mx, r5_rr;
    logic [PW-1:0]  w_parr, w_pxx2;
    logic [DDW-1:0] r7_d;

    logic [CW-1:0]  w_d4, w_t, w_nt;
    t_flag          n_flag;
    logic [SQW-1:0] w_s;

    t_flag          w_f8;
    t_mid           w_m8;
    t_keep          w_k8;
    logic [NSW-1:0] w_nb, w_sx8;
    logic [NSW-1:0] r9_n0, r9_n1;
    logic           r9_c1, r9_c2;

    t_mid           w_m9;
    t_ok            n_ok;
    logic [AW-1:0]  r10_n0u, r10_n1u;

    t_keep          w_k10;
    logic [DW+AW-1:0] w_p0x, w_p0y, w_p1x, w_p1y;
    logic [AW-1:0]  w_a11;
    logic [DW-1:0]  w_q0x, w_q0y, w_q1x, w_q1y;

    t_keep          w_k12;
    t_ok            w_t12;
    logic [W-1:0]   w_x0, w_y0, w_x1, w_y1;
    logic [OUT_TDW-1:0] n_out;
    logic [OUT_TDW-1:0] r_out;
    logic           r_degen;

    // advance every stage unless the output holds an untaken item
    assign ce              = ~r_v[S13] | i_m_axis_tready;
    assign o_s_axis_tready = ce & i_rst_n;
    assign o_m_axis_tvalid = r_v[S13];
    assign o_m_axis_tdata  = r_out;
    assign o_m_axis_tuser  = r_degen;

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tol2 <= (2*TOL_W)'(r_tol) * (2*TOL_W)'(r_tol);
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= S13; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (ce) begin
            r_v[1] <= i_s_axis_tvalid;
            for (int i = 2; i <= S13; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    // unpack the input item
    assign w_sx  = i_s_axis_tdata[0*W +: W];
    assign w_sy  = i_s_axis_tdata[1*W +: W];
    assign w_ex  = i_s_axis_tdata[2*W +: W];
    assign w_ey  = i_s_axis_tdata[3*W +: W];
    assign w_cx  = i_s_axis_tdata[4*W +: W];
    assign w_cy  = i_s_axis_tdata[5*W +: W];
    assign w_rad = i_s_axis_tdata[6*W +: W-1];

    // stage 1: direction d = end - start and offset e = start - center
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_dx <= {w_ex[W-1], w_ex} - {w_sx[W-1], w_sx};
            r1_dy <= {w_ey[W-1], w_ey} - {w_sy[W-1], w_sy};
            r1_ex <= {w_sx[W-1], w_sx} - {w_cx[W-1], w_cx};
            r1_ey <= {w_sy[W-1], w_sy} - {w_cy[W-1], w_cy};
            r1_sx <= w_sx;
            r1_sy <= w_sy;
            r1_r  <= w_rad;
        end
    end

    // stage 2: split into magnitude and sign
    always_comb begin
        n_keep.sx    = r1_sx;
        n_keep.sy    = r1_sy;
        n_keep.mdx   = r1_dx[DW-1] ? -r1_dx : r1_dx;
        n_keep.mdy   = r1_dy[DW-1] ? -r1_dy : r1_dy;
        n_keep.sdx   = r1_dx[DW-1];
        n_keep.sdy   = r1_dy[DW-1];
        n_keep.sex   = r1_ex[DW-1];
        n_keep.sey   = r1_ey[DW-1];
        n_keep.degen = (r1_dx == '0) && (r1_dy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r2_mex <= r1_ex[DW-1] ? -r1_ex : r1_ex;
            r2_mey <= r1_ey[DW-1] ? -r1_ey : r1_ey;
            r2_r   <= DW'(r1_r);
            r_keep[0] <= n_keep;
            for (int i = 1; i < KL; i++) begin
                r_keep[i] <= r_keep[i-1];
            end
        end
    end

    // first products
    scic_mul #(.A_W(DW), .B_W(DW)) u_mul_xx (.i_clk(i_clk), .i_ce(ce),
        .i_a(r_keep[0].mdx), .i_b(r_keep[0].mdx), .o_p(w_pxx));
    scic_mul #(.A_W(DW), .B_W(DW)) u_mul_yy (.i_clk(i_clk), .i_ce(ce),
        .i_a(r_keep[0].mdy), .i_b(r_keep[0].mdy), .o_p(w_pyy));
    scic_mul #(.A_W(DW), .B_W(DW)) u_mul_xe (.i_clk(i_clk), .i_ce(ce),
        .i_a(r_keep[0].mdx), .i_b(r2_mex), .o_p(w_pxe));
    scic_mul #(.A_W(DW), .B_W(DW)) u_mul_ye (.i_clk(i_clk), .i_ce(ce),
        .i_a(r_keep[0].mdy), .i_b(r2_mey), .o_p(w_pye));
    scic_mul #(.A_W(DW), .B_W(DW)) u_mul_xy (.i_clk(i_clk), .i_ce(ce),
        .i_a(r_keep[0].mdx), .i_b(r2_mey), .o_p(w_pxy));
    scic_mul #(.A_W(DW), .B_W(DW)) u_mul_yx (.i_clk(i_clk), .i_ce(ce),
        .i_a(r_keep[0].mdy), .i_b(r2_mex), .o_p(w_pyx));
    scic_mul #(.A_W(DW), .B_W(DW)) u_mul_rr (.i_clk(i_clk), .i_ce(ce),
        .i_a(r2_r), .i_b(r2_r), .o_p(w_prr));

    // stage S4: A = d.d, B = d.e, X = d cross e
    assign w_k3 = r_keep[S3-S2];

    always_comb begin
        n_mid.a = AW'(w_pxx) + AW'(w_pyy);
        n_mid.b = ((w_k3.sdx ^ w_k3.sex) ? -BW'(w_pxe) : BW'(w_pxe))
                + ((w_k3.sdy ^ w_k3.sey) ? -BW'(w_pye) : BW'(w_pye));
        n_x     = ((w_k3.sdx ^ w_k3.sey) ? -BW'(w_pxy) : BW'(w_pxy))
                - ((w_k3.sdy ^ w_k3.sex) ? -BW'(w_pyx) : BW'(w_pyx));
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r4_x  <= n_x;
            r4_rr <= w_prr;
            r_mid[0] <= n_mid;
            for (int i = 1; i < ML; i++) begin
                r_mid[i] <= r_mid[i-1];
            end
        end
    end

    // stage S5: magnitude of the cross product
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r5_mx <= r4_x[BW-1] ? AW'(-r4_x) : AW'(r4_x);
            r5_rr <= r4_rr;
        end
    end

    // quarter discriminant D = A*r^2 - X^2
    scic_mul #(.A_W(AW), .B_W(AW)) u_mul_arr (.i_clk(i_clk), .i_ce(ce),
        .i_a(r_mid[S5-S4].a), .i_b(r5_rr), .o_p(w_parr));
    scic_mul #(.A_W(AW), .B_W(AW)) u_mul_x2 (.i_clk(i_clk), .i_ce(ce),
        .i_a(r5_mx), .i_b(r5_mx), .o_p(w_pxx2));

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r7_d <= DDW'(w_parr) - DDW'(w_pxx2);
        end
    end

    // classify 4D against the tolerance band
    assign w_d4 = {{(CW-DDW-2){r7_d[DDW-1]}}, r7_d, 2'b00};
    assign w_t  = CW'(r_tol2) << (2 * FRAC_BITS);
    assign w_nt = -w_t;

    always_comb begin
        n_flag.neg  = $signed(w_d4) < $signed(w_nt);
        n_flag.tang = ($signed(w_d4) > $signed(w_nt)) && ($signed(w_d4) < $signed(w_t));
        n_flag.dpos = ~r7_d[DDW-1];
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_flag[0] <= n_flag;
            for (int i = 1; i < FL; i++) begin
                r_flag[i] <= r_flag[i-1];
            end
        end
    end

    scic_sqrt #(.Q_W(SQW)) u_sqrt (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_x   (r7_d[DDW-1] ? '0 : r7_d[2*SQW-1:0]),
        .o_q   (w_s)
    );

    // stage S9: candidate numerators
    assign w_f8  = r_flag[FL-1];
    assign w_m8  = r_mid[S8-S4];
    assign w_k8  = r_keep[S8-S2];
    assign w_nb  = -{w_m8.b[BW-1], w_m8.b};
    assign w_sx8 = NSW'(w_s);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r9_n0 <= w_f8.tang ? w_nb : w_nb - w_sx8;
            r9_n1 <= w_nb + w_sx8;
            r9_c1 <= ~w_k8.degen & ~w_f8.neg & (w_f8.tang | w_f8.dpos);
            r9_c2 <= ~w_k8.degen & ~w_f8.neg & ~w_f8.tang & w_f8.dpos;
        end
    end

    // stage S10: keep roots inside the segment
    assign w_m9 = r_mid[S9-S4];

    always_comb begin
        n_ok.ok0 = r9_c1 & ~r9_n0[NSW-1] & (r9_n0[NSW-2:0] <= (NSW-1)'(w_m9.a));
        n_ok.ok1 = r9_c2 & ~r9_n1[NSW-1] & (r9_n1[NSW-2:0] <= (NSW-1)'(w_m9.a));
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r10_n0u <= r9_n0[AW-1:0];
            r10_n1u <= r9_n1[AW-1:0];
            r_tail[0] <= n_ok;
            for (int i = 1; i < TL; i++) begin
                r_tail[i] <= r_tail[i-1];
            end
        end
    end

    // offsets along the segment: |d| * n / A
    assign w_k10 = r_keep[S10-S2];
    assign w_a11 = r_mid[S11-S4].a;

    scic_mul #(.A_W(DW), .B_W(AW)) u_mul_0x (.i_clk(i_clk), .i_ce(ce),
        .i_a(w_k10.mdx), .i_b(r10_n0u), .o_p(w_p0x));
    scic_mul #(.A_W(DW), .B_W(AW)) u_mul_0y (.i_clk(i_clk), .i_ce(ce),
        .i_a(w_k10.mdy), .i_b(r10_n0u), .o_p(w_p0y));
    scic_mul #(.A_W(DW), .B_W(AW)) u_mul_1x (.i_clk(i_clk), .i_ce(ce),
        .i_a(w_k10.mdx), .i_b(r10_n1u), .o_p(w_p1x));
    scic_mul #(.A_W(DW), .B_W(AW)) u_mul_1y (.i_clk(i_clk), .i_ce(ce),
        .i_a(w_k10.mdy), .i_b(r10_n1u), .o_p(w_p1y));

    scic_div #(.N_W(DW+AW), .D_W(AW), .Q_W(DW)) u_div_0x (.i_clk(i_clk), .i_ce(ce),
        .i_num(w_p0x), .i_den(w_a11), .o_q(w_q0x));
    scic_div #(.N_W(DW+AW), .D_W(AW), .Q_W(DW)) u_div_0y (.i_clk(i_clk), .i_ce(ce),
        .i_num(w_p0y), .i_den(w_a11), .o_q(w_q0y));
    scic_div #(.N_W(DW+AW), .D_W(AW), .Q_W(DW)) u_div_1x (.i_clk(i_clk), .i_ce(ce),
        .i_num(w_p1x), .i_den(w_a11), .o_q(w_q1x));
    scic_div #(.N_W(DW+AW), .D_W(AW), .Q_W(DW)) u_div_1y (.i_clk(i_clk), .i_ce(ce),
        .i_num(w_p1y), .i_den(w_a11), .o_q(w_q1y));

    // output stage: place points and pack the result item
    assign w_k12 = r_keep[S12-S2];
    assign w_t12 = r_tail[TL-1];
    assign w_x0  = w_k12.sdx ? w_k12.sx - w_q0x[W-1:0] : w_k12.sx + w_q0x[W-1:0];
    assign w_y0  = w_k12.sdy ? w_k12.sy - w_q0y[W-1:0] : w_k12.sy + w_q0y[W-1:0];
    assign w_x1  = w_k12.sdx ? w_k12.sx - w_q1x[W-1:0] : w_k12.sx + w_q1x[W-1:0];
    assign w_y1  = w_k12.sdy ? w_k12.sy - w_q1y[W-1:0] : w_k12.sy + w_q1y[W-1:0];

    always_comb begin
        n_out = '0;
        n_out[1:0] = {w_t12.ok0 & w_t12.ok1, w_t12.ok0 ^ w_t12.ok1};
        if (w_t12.ok0) begin
            n_out[2 +: W]     = w_x0;
            n_out[2+W +: W]   = w_y0;
            if (w_t12.ok1) begin
                n_out[2+2*W +: W] = w_x1;
                n_out[2+3*W +: W] = w_y1;
            end
        end else if (w_t12.ok1) begin
            n_out[2 +: W]     = w_x1;
            n_out[2+W +: W]   = w_y1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out   <= n_out;
            r_degen <= w_k12.degen;
        end
    end

endmodule
`default_nettype wire

@@ design/scic_mul.sv @@
// Pipelined unsigned multiplier: one slice product accumulated per stage.
`timescale 1ns / 1ps
`default_nettype none
module scic_mul
    import scic_pkg::*;
#(
    parameter int A_W = 33,
    parameter int B_W = 33
) (
    input  wire logic           i_clk,
    input  wire logic           i_ce,
    input  wire logic [A_W-1:0] i_a,
    input  wire logic [B_W-1:0] i_b,
    output logic [A_W+B_W-1:0]  o_p
);

    localparam int CH   = MUL_CHUNK;
    localparam int NA   = (A_W + CH - 1) / CH;
    localparam int NB   = (B_W + CH - 1) / CH;
    localparam int NS   = NA * NB;
    localparam int PADA = NA * CH;
    localparam int PADB = NB * CH;
    localparam int PW   = PADA + PADB;

    logic [PADA-1:0] r_a   [NS];
    logic [PADB-1:0] r_b   [NS];
    logic [PW-1:0]   r_acc [NS];

    for (genvar k = 0; k < NS; k++) begin : g_st
        localparam int IA = k / NB;
        localparam int IB = k % NB;
        logic [PADA-1:0] w_a;
        logic [PADB-1:0] w_b;
        logic [PW-1:0]   w_acc;
        logic [2*CH-1:0] w_pp;

        if (k == 0) begin : g_first
            assign w_a   = PADA'(i_a);
            assign w_b   = PADB'(i_b);
            assign w_acc = '0;
        end else begin : g_next
            assign w_a   = r_a[k-1];
            assign w_b   = r_b[k-1];
            assign w_acc = r_acc[k-1];
        end

        // one slice product per stage
        assign w_pp = w_a[IA*CH +: CH] * w_b[IB*CH +: CH];

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_a[k]   <= w_a;
                r_b[k]   <= w_b;
                r_acc[k] <= w_acc + (PW'(w_pp) << ((IA + IB) * CH));
            end
        end
    end

    assign o_p = r_acc[NS-1][A_W+B_W-1:0];

endmodule
`default_nettype wire

@@ design/scic_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module scic_sqrt #(
    parameter int Q_W = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_ce,
    input  wire logic [2*Q_W-1:0] i_x,
    output logic [Q_W-1:0]        o_q
);

    logic [Q_W+1:0]   r_rem  [Q_W];
    logic [Q_W-1:0]   r_root [Q_W];
    logic [2*Q_W-1:0] r_x    [Q_W];

    for (genvar i = 0; i < Q_W; i++) begin : g_st
        logic [Q_W+1:0]   w_rem;
        logic [Q_W-1:0]   w_root;
        logic [2*Q_W-1:0] w_x;
        logic [Q_W+1:0]   w_t;
        logic [Q_W+1:0]   w_trial;
        logic             w_ge;

        if (i == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_x    = i_x;
        end else begin : g_next
            assign w_rem  = r_rem[i-1];
            assign w_root = r_root[i-1];
            assign w_x    = r_x[i-1];
        end

        // bring down two radicand bits and try the next root bit
        assign w_t     = {w_rem[Q_W-1:0], w_x[2*Q_W-1 -: 2]};
        assign w_trial = {w_root, 2'b01};
        assign w_ge    = w_t >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[i]  <= w_ge ? w_t - w_trial : w_t;
                r_root[i] <= {w_root[Q_W-2:0], w_ge};
                r_x[i]    <= {w_x[2*Q_W-3:0], 2'b00};
            end
        end
    end

    assign o_q = r_root[Q_W-1];

endmodule
`default_nettype wire

@@ design/scic_div.sv @@
// Pipelined restoring divider with round-half-up of the quotient.
`timescale 1ns / 1ps
`default_nettype none
module scic_div #(
    parameter int N_W = 99,
    parameter int D_W = 66,
    parameter int Q_W = 33
) (
    input  wire logic           i_clk,
    input  wire logic           i_ce,
    input  wire logic [N_W-1:0] i_num,
    input  wire logic [D_W-1:0] i_den,
    output logic [Q_W-1:0]      o_q
);

    logic [N_W-1:0] r_rem [Q_W];
    logic [D_W-1:0] r_den [Q_W];
    logic [Q_W-1:0] r_q   [Q_W];
    logic [Q_W-1:0] r_qf;
    logic           w_up;

    for (genvar j = 0; j < Q_W; j++) begin : g_st
        localparam int K  = Q_W - 1 - j;
        localparam int HW = N_W - K;
        logic [N_W-1:0] w_num;
        logic [N_W-1:0] w_rem;
        logic [D_W-1:0] w_den;
        logic [Q_W-1:0] w_q;
        logic [HW-1:0]  w_hi;
        logic           w_ge;

        if (j == 0) begin : g_first
            assign w_num = i_num;
            assign w_den = i_den;
            assign w_q   = '0;
        end else begin : g_next
            assign w_num = r_rem[j-1];
            assign w_den = r_den[j-1];
            assign w_q   = r_q[j-1];
        end

        // subtract the shifted divisor where it fits
        assign w_hi = w_num[N_W-1:K];
        assign w_ge = w_hi >= HW'(w_den);

        always_comb begin
            w_rem = w_num;
            if (w_ge) begin
                w_rem[N_W-1:K] = w_hi - HW'(w_den);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[j] <= w_rem;
                r_den[j] <= w_den;
                r_q[j]   <= {w_q[Q_W-2:0], w_ge};
            end
        end
    end

    // round to nearest: bump when twice the remainder reaches the divisor
    assign w_up = {r_rem[Q_W-1][D_W-1:0], 1'b0} >= {1'b0, r_den[Q_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_qf <= r_q[Q_W-1] + Q_W'(w_up);
        end
    end

    assign o_q = r_qf;

endmodule
`default_nettype wire
